>>> design/lfuc_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lfuc_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;
	localparam int ENTRY_W = KEY_W + VALUE_W + COUNT_W + STAMP_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);
	localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request and clear the scan results
		logic rd_en;   // read one entry at the scan address
		logic commit;  // write back, update bookkeeping, present the result
	} ctrl_cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

>>> design/lfu_cache_lru_tiebreak_top.sv
// Top level of the LFU cache with LRU tie-break.
// Instantiates lfuc_ctrl and lfuc_datapath; depends on lfuc_pkg.
//
// Usage: a request (operation, key, value) is taken at a rising edge where
// start is high and busy is low. operation 0 is a get, 1 is a put. busy stays
// high while the request is processed. Every request gives exactly one result:
// done is high for a single cycle with hit, read_value, evicted and
// evicted_key valid alongside it. The receiver cannot stall the result.
// Sequence: after accept, the scan reads one entry per cycle through the single
// read port of the entry memory, then the last compare and the write-back
// follow before done. The next request can be accepted in the cycle done is
// high.
// Configuration: capacity is written through cfg_valid/cfg_ready/cfg_data
// while the block is idle; values above ENTRIES act as ENTRIES.
// Reset: arst_n empties the cache, clears the use clock and sets capacity
// to sixteen. No clearing pass is needed; the block is ready at once.
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_top import lfuc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [KEY_W-1:0]   key,
	input  logic [VALUE_W-1:0] value,
	output logic               done,
	output logic               hit,
	output logic [VALUE_W-1:0] read_value,
	output logic               evicted,
	output logic [KEY_W-1:0]   evicted_key,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   cfg_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] ENTRIES_EXT = CMP_W'(ENTRIES);

	ctrl_cmd_t        cmd;
	logic [IDX_W-1:0] rd_addr;
	logic [CAP_W-1:0] capacity_q;
	logic [CAP_W-1:0] cap_eff;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	assign cap_eff = (CMP_W'(capacity_q) > ENTRIES_EXT) ? CAP_W'(ENTRIES_EXT) : capacity_q;

	lfuc_ctrl #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.rd_addr (rd_addr)
	);

	lfuc_datapath #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W),
		.CNT_W   (CNT_W)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.cap_eff     (cap_eff),
		.in_op       (operation),
		.in_key      (key),
		.in_value    (value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule

>>> design/lfuc_ctrl.sv
// Controller of the LFU cache: sequences accept, the entry scan and the commit.
// Depends on lfuc_pkg for the command struct.
`timescale 1ns / 1ps

module lfuc_ctrl import lfuc_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output ctrl_cmd_t        cmd,
	output logic [IDX_W-1:0] rd_addr
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) idx_q <= idx_q + IDX_W'(1);
			else idx_q <= '0;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.rd_en  = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_COMMIT);
	assign rd_addr    = idx_q;

endmodule

>>> design/lfuc_datapath.sv
// Datapath of the LFU cache: entry memory, valid bits, scan trackers,
// write-back logic and result registers. Depends on lfuc_pkg.
`timescale 1ns / 1ps

module lfuc_datapath import lfuc_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4,
	parameter int CNT_W   = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [IDX_W-1:0]   rd_addr,
	input  logic [CAP_W-1:0]   cap_eff,
	input  logic               in_op,
	input  logic [KEY_W-1:0]   in_key,
	input  logic [VALUE_W-1:0] in_value,
	output logic               done,
	output logic               hit,
	output logic [VALUE_W-1:0] read_value,
	output logic               evicted,
	output logic [KEY_W-1:0]   evicted_key
);

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	entry_t mem [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_d;
	logic [STAMP_W-1:0] clock_q;

	// Request held for the whole operation.
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	// Read stage.
	entry_t           rd_data_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             cmp_en_s1;

	// Scan trackers.
	logic               found_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic [VALUE_W-1:0] found_value_q;
	logic [COUNT_W-1:0] found_count_q;
	logic               victim_q;
	logic [IDX_W-1:0]   victim_idx_q;
	logic [KEY_W-1:0]   victim_key_q;
	logic [COUNT_W-1:0] victim_count_q;
	logic [STAMP_W-1:0] victim_stamp_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [CNT_W-1:0]   used_q;

	logic               slot_valid;
	logic               older;
	logic               do_insert;
	logic               do_evict;
	logic [IDX_W-1:0]   ins_idx;
	logic [COUNT_W-1:0] count_inc;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	assign slot_valid = valid_q[idx_s1];
	assign older = (rd_data_s1.count < victim_count_q) ||
		((rd_data_s1.count == victim_count_q) && (rd_data_s1.stamp < victim_stamp_q));

	// A miss put only stores when capacity is nonzero; it evicts when occupancy
	// has reached capacity.
	assign do_insert = !found_q && (op_q == OP_PUT) && (cap_eff != '0);
	assign do_evict  = do_insert && victim_q && (CMP_W'(used_q) >= CMP_W'(cap_eff));
	assign ins_idx   = (do_evict && (!free_q || (victim_idx_q < free_idx_q))) ?
		victim_idx_q : free_idx_q;
	assign count_inc = (found_count_q == COUNT_MAX) ? found_count_q :
		found_count_q + COUNT_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ins_idx;
		wr_data.key   = key_q;
		wr_data.value = value_q;
		wr_data.count = COUNT_FIRST;
		wr_data.stamp = clock_q;
		if (cmd.commit) begin
			if (found_q) begin
				wr_en   = 1'b1;
				wr_addr = found_idx_q;
				wr_data.value = (op_q == OP_PUT) ? value_q : found_value_q;
				wr_data.count = count_inc;
			end else if (do_insert) begin
				wr_en = 1'b1;
			end
		end
	end

	always_comb begin
		valid_d = valid_q;
		if (cmd.commit && !found_q && do_insert) begin
			// Clear the victim first so that reusing its slot keeps it valid.
			if (do_evict) valid_d[victim_idx_q] = 1'b0;
			valid_d[ins_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			value_q <= in_value;
		end
		if (cmp_en_s1) begin
			if (slot_valid && (rd_data_s1.key == key_q) && !found_q) begin
				found_idx_q   <= idx_s1;
				found_value_q <= rd_data_s1.value;
				found_count_q <= rd_data_s1.count;
			end
			if (slot_valid && (!victim_q || older)) begin
				victim_idx_q   <= idx_s1;
				victim_key_q   <= rd_data_s1.key;
				victim_count_q <= rd_data_s1.count;
				victim_stamp_q <= rd_data_s1.stamp;
			end
			if (!slot_valid && !free_q) free_idx_q <= idx_s1;
		end
		if (cmd.commit) begin
			hit         <= found_q;
			read_value  <= (found_q && (op_q == OP_GET)) ? found_value_q : '0;
			evicted     <= do_evict;
			evicted_key <= do_evict ? victim_key_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			clock_q   <= '0;
			cmp_en_s1 <= 1'b0;
			found_q   <= 1'b0;
			victim_q  <= 1'b0;
			free_q    <= 1'b0;
			used_q    <= '0;
			done      <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.rd_en;
			done      <= cmd.commit;
			valid_q   <= valid_d;
			if (cmd.load) begin
				found_q  <= 1'b0;
				victim_q <= 1'b0;
				free_q   <= 1'b0;
				used_q   <= '0;
			end else if (cmp_en_s1) begin
				if (slot_valid) begin
					used_q   <= used_q + CNT_W'(1);
					victim_q <= 1'b1;
					if (rd_data_s1.key == key_q) found_q <= 1'b1;
				end else begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && (found_q || do_insert)) begin
				clock_q <= clock_q + STAMP_W'(1);
			end
		end
	end

endmodule
